[sv/cbm_pkg.sv]
`default_nettype none
package cbm_pkg;

  // fixed geometry of the mapper
  localparam int BankW     = 7;   // full ROM bank number
  localparam int CountW    = 8;   // rom_bank_count register
  localparam int RamSizeW  = 16;  // ram_size_bytes register
  localparam int RomOffW   = 14;  // offset inside a 16 KiB ROM bank
  localparam int RamOffW   = 13;  // offset inside an 8 KiB RAM bank
  localparam int PhysW     = 21;

  localparam logic [CountW-1:0]   MAX_ROM_BANKS      = 8'd128;
  localparam logic [CountW-1:0]   ROM_COUNT_RESET    = 8'd2;
  localparam logic [RamSizeW-1:0] RAM_SIZE_RESET     = 16'd0;
  localparam logic [4:0]          BANK_LOW_RESET     = 5'd1;
  localparam logic [3:0]          RAM_ENABLE_KEY     = 4'hA;
  localparam logic [2:0]          RAM_WINDOW_TOP     = 3'b101;

  // register indexes on the config port
  localparam logic CFG_ROM_BANK_COUNT = 1'b0;
  localparam logic CFG_RAM_SIZE       = 1'b1;

  typedef enum logic [1:0] {
    TGT_NONE   = 2'd0,
    TGT_ROM    = 2'd1,
    TGT_RAM_RD = 2'd2,
    TGT_RAM_WR = 2'd3
  } target_t;

  // request into the shared remainder unit
  typedef struct packed {
    logic              start;
    logic [BankW-1:0]  dividend;
    logic [CountW-1:0] divisor;
  } rem_req_t;

  // answer from the remainder unit
  typedef struct packed {
    logic             done;
    logic [BankW-1:0] remainder;
  } rem_rsp_t;

endpackage
`default_nettype wire

[sv/cartridge_bank_mapper.sv]
// A ROM read goes from accept through the 7-step bit-serial remainder unit, after its
// load, then the result register and the output register; other accesses skip the unit.
// A new access is taken only once the last result has moved to the output register;
// a low m_tready holds the pending result.
// Reset (rst, synchronous): RAM disabled, low bank 1, high bank 0, simple mode,
// rom_bank_count 2, ram_size_bytes 0, no word pending.
`default_nettype none
module cartridge_bank_mapper
  import cbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  // bus access in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] address, [23:16] data
  input  wire logic        s_tuser,   // [0] mode (1 write)
  // mapping result out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [20:0] phys_addr, zero padded
  output logic [1:0]       m_tuser    // [1:0] target
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_FIN
  } state_t;

  state_t state;

  // config and banking registers
  logic [CountW-1:0]   rom_bank_count;
  logic [RamSizeW-1:0] ram_size_bytes;
  logic                ram_on;
  logic [4:0]          bank_low;
  logic [1:0]          bank_high;
  logic                advanced_mode;

  logic [15:0] addr;
  logic [7:0]  wdata;
  logic        wr;
  logic        accept;

  assign addr   = s_tdata[15:0];
  assign wdata  = s_tdata[23:16];
  assign wr     = s_tuser;
  assign accept = s_tvalid && s_tready;

  // bank count saturated to the largest ROM
  logic [CountW-1:0] count_eff;
  assign count_eff = (rom_bank_count > MAX_ROM_BANKS) ? MAX_ROM_BANKS : rom_bank_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count <= ROM_COUNT_RESET;
      ram_size_bytes <= RAM_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROM_BANK_COUNT: rom_bank_count <= cfg_data[CountW-1:0];
        CFG_RAM_SIZE:       ram_size_bytes <= cfg_data;
        default:            ;
      endcase
    end
  end

  // mapper control writes at 0000-7FFF
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_on        <= 1'b0;
      bank_low      <= BANK_LOW_RESET;
      bank_high     <= 2'd0;
      advanced_mode <= 1'b0;
    end else if (accept && wr && !addr[15]) begin
      unique case (addr[14:13])
        2'd0: ram_on <= (wdata[3:0] == RAM_ENABLE_KEY);
        2'd1: bank_low <= (wdata[4:0] == 5'd0) ? BANK_LOW_RESET : wdata[4:0];
        2'd2: bank_high <= wdata[1:0];
        2'd3: advanced_mode <= wdata[0];
        default: ;
      endcase
    end
  end

  // decode of the incoming access
  logic              is_rom_rd;
  logic              upper_win;
  logic [BankW-1:0]  rom_bank_raw;
  logic [14:0]       ram_off;
  logic              ram_hit;
  target_t           quick_tgt;
  logic [PhysW-1:0]  quick_phys;

  always_comb begin
    is_rom_rd = !wr && !addr[15];
    upper_win = addr[14];
    if (upper_win) begin
      rom_bank_raw = {bank_high, bank_low};
    end else if (advanced_mode) begin
      rom_bank_raw = {bank_high, 5'd0};
    end else begin
      rom_bank_raw = '0;
    end
    ram_off = {(advanced_mode ? bank_high : 2'd0), addr[RamOffW-1:0]};
    ram_hit = (addr[15:13] == RAM_WINDOW_TOP) && ram_on &&
              ({1'b0, ram_off} < ram_size_bytes);
    quick_tgt  = TGT_NONE;
    quick_phys = '0;
    if (ram_hit) begin
      quick_tgt  = wr ? TGT_RAM_WR : TGT_RAM_RD;
      quick_phys = PhysW'(ram_off);
    end
  end

  // shared remainder unit: bank % count
  rem_req_t rreq;
  rem_rsp_t rrsp;
  logic     rom_start;

  assign rom_start     = accept && is_rom_rd && (count_eff != '0);
  assign rreq.start    = rom_start;
  assign rreq.dividend = rom_bank_raw;
  assign rreq.divisor  = count_eff;

  cbm_rem_unit u_rem (
    .clk (clk),
    .rst (rst),
    .req (rreq),
    .rsp (rrsp)
  );

  // ROM result once the remainder is in
  logic              upper_q;
  logic [RomOffW-1:0] within_q;
  logic [BankW-1:0]  bank_b;
  logic              in_rom;

  always_comb begin
    bank_b = rrsp.remainder;
    if (upper_q && (rrsp.remainder[4:0] == 5'd0)) begin
      bank_b = rrsp.remainder + 7'd1;
    end
    in_rom = ({1'b0, bank_b} < count_eff);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upper_q  <= upper_win;
      within_q <= addr[RomOffW-1:0];
    end
  end

  // sequencer and output register
  target_t          res_tgt;
  logic [PhysW-1:0] res_phys;
  target_t          out_tgt;
  logic [PhysW-1:0] out_phys;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_FIN) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            res_tgt  <= quick_tgt;
            res_phys <= quick_phys;
            state    <= rom_start ? ST_BUSY : ST_FIN;
          end
        end
        ST_BUSY: begin
          if (rrsp.done) begin
            res_tgt  <= in_rom ? TGT_ROM : TGT_NONE;
            res_phys <= in_rom ? {bank_b, within_q} : '0;
            state    <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            out_tgt  <= res_tgt;
            out_phys <= res_phys;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {3'd0, out_phys};
  assign m_tuser  = out_tgt;

endmodule
`default_nettype wire

[sv/cbm_rem_unit.sv]
`default_nettype none
module cbm_rem_unit
  import cbm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire rem_req_t req,
  output rem_rsp_t      rsp
);

  logic              running;
  logic [2:0]        steps;
  logic [BankW-1:0]  dvd;
  logic [BankW-1:0]  rem;
  logic [CountW-1:0] dvs;
  logic              done;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  logic [CountW-1:0] trial;
  logic [CountW-1:0] diff;
  logic [BankW-1:0]  rem_next;

  always_comb begin
    trial = {rem, dvd[BankW-1]};
    diff  = trial - dvs;
    if (trial >= dvs) begin
      rem_next = diff[BankW-1:0];
    end else begin
      rem_next = trial[BankW-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      steps   <= '0;
      done    <= 1'b0;
    end else if (req.start) begin
      running <= 1'b1;
      steps   <= 3'(BankW);
      done    <= 1'b0;
    end else if (running) begin
      steps <= steps - 3'd1;
      if (steps == 3'd1) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= {dvd[BankW-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import cbm_pkg::*;

  // bus access waiting to be driven
  typedef struct {
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_access_t;

  // where an access lands
  typedef struct {
    target_t     tgt;
    logic [20:0] phys;
  } mapping_t;

  localparam int RomBankBytes = 16384;
  localparam int RamBankBytes = 8192;
  localparam int StallMax     = 13;
  localparam int WatchdogMax  = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_ROM_BANK_COUNT;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [15:0] address, [23:16] data
  logic        s_tuser = 1'b0; // [0] mode (1 write)
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [20:0] phys_addr, zero padded
  logic [1:0]  m_tuser;        // [1:0] target

  cartridge_bank_mapper dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the mapper registers
  logic [7:0]  rom_count_m = ROM_COUNT_RESET;
  logic [15:0] ram_size_m  = RAM_SIZE_RESET;
  logic        ram_on_m    = 1'b0;
  logic [4:0]  bank_lo_m   = BANK_LOW_RESET;
  logic [1:0]  bank_hi_m   = 2'd0;
  logic        adv_m       = 1'b0;

  bus_access_t access_q[$];
  mapping_t    mapping_q[$];
  int          errors = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int          tx_gap = 0;
  int          rx_wait = 0;
  int          idle_cycles = 0;

  // map one access and update the bank registers
  function automatic mapping_t map_access(logic wr, logic [15:0] addr, logic [7:0] data);
    mapping_t    r;
    int unsigned cnt;
    int unsigned bank;
    int unsigned off;
    r.tgt  = TGT_NONE;
    r.phys = '0;
    cnt = 32'((rom_count_m > MAX_ROM_BANKS) ? MAX_ROM_BANKS : rom_count_m);
    if (wr && !addr[15]) begin
      case (addr[14:13])
        2'd0: ram_on_m = (data[3:0] == RAM_ENABLE_KEY);
        2'd1: bank_lo_m = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
        2'd2: bank_hi_m = data[1:0];
        default: adv_m = data[0];
      endcase
    end else if (!wr && !addr[15]) begin
      if (cnt != 0) begin
        if (!addr[14]) begin
          bank = adv_m ? 32'({bank_hi_m, 5'd0}) : 0;
          bank = bank % cnt;
        end else begin
          bank = 32'({bank_hi_m, bank_lo_m});
          bank = bank % cnt;
          // bank 0, 32, 64, 96 cannot sit in the upper window
          if ((bank % 32) == 0) bank = bank + 1;
        end
        off = bank * RomBankBytes + 32'(addr[13:0]);
        if (off < cnt * RomBankBytes) begin
          r.tgt  = TGT_ROM;
          r.phys = off[20:0];
        end
      end
    end else if (addr[15:13] == RAM_WINDOW_TOP && ram_on_m) begin
      off = 32'(adv_m ? bank_hi_m : 2'd0) * RamBankBytes + 32'(addr[12:0]);
      if (off < ram_size_m) begin
        r.tgt  = wr ? TGT_RAM_WR : TGT_RAM_RD;
        r.phys = off[20:0];
      end
    end
    return r;
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, StallMax);
  endfunction

  // driver: feeds queued accesses, predicts on accept
  always @(posedge clk) begin
    bus_access_t a;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (s_tvalid && s_tready)
        mapping_q.push_back(map_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (access_q.size() != 0) begin
          a = access_q.pop_front();
          s_tdata  <= {a.data, a.addr};
          s_tuser  <= a.wr;
          s_tvalid <= 1'b1;
          tx_gap   <= draw_gap(tx_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compare against oldest prediction
  always @(posedge clk) begin
    mapping_t e;
    int       w;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait  <= 0;
    end else if (m_tvalid && m_tready) begin
      if (mapping_q.size() == 0) begin
        $error("result word with nothing pending: target %0d phys_addr 0x%06h",
               m_tuser, m_tdata);
        errors++;
      end else begin
        e = mapping_q.pop_front();
        if (m_tuser !== e.tgt) begin
          $error("target: expected %0d, got %0d", e.tgt, m_tuser);
          errors++;
        end
        if (m_tdata !== {3'b000, e.phys}) begin
          $error("phys_addr: expected 0x%06h, got 0x%06h", e.phys, m_tdata);
          errors++;
        end
      end
      w = draw_gap(rx_calm);
      rx_wait  <= w;
      m_tready <= (w == 0);
    end else if (rx_wait != 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogMax) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_ROM_BANK_COUNT) rom_count_m = val[7:0];
    else ram_size_m = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_access(logic wr, logic [15:0] addr, logic [7:0] data);
    bus_access_t a;
    a.wr   = wr;
    a.addr = addr;
    a.data = data;
    access_q.push_back(a);
  endtask

  // mostly bank setup and mapped reads, some noise over the whole bus
  task automatic push_random_access();
    int          kind;
    logic [15:0] addr;
    logic [7:0]  data;
    kind = $urandom_range(0, 99);
    data = 8'($urandom_range(0, 255));
    if (kind < 25) begin
      addr = 16'($urandom_range(16'h0000, 16'h7FFF));
      if (addr[14:13] == 2'd0 && $urandom_range(0, 1)) data[3:0] = RAM_ENABLE_KEY;
      if (addr[14:13] == 2'd1 && $urandom_range(0, 5) == 0) data[4:0] = 5'd0;
      push_access(1'b1, addr, data);
    end else if (kind < 60) begin
      push_access(1'b0, 16'($urandom_range(16'h0000, 16'h7FFF)), data);
    end else if (kind < 85) begin
      push_access(1'($urandom_range(0, 1)), 16'($urandom_range(16'hA000, 16'hBFFF)), data);
    end else begin
      push_access(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)), data);
    end
  endtask

  // hold the sender until every prediction has been answered
  task automatic drain();
    do @(negedge clk);
    while (access_q.size() != 0 || s_tvalid || mapping_q.size() != 0);
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      push_random_access();
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: two banks, no RAM
    push_access(1'b0, 16'h0000, 8'h00);
    push_access(1'b0, 16'h3FFF, 8'hFF);
    push_access(1'b0, 16'h4000, 8'h00);
    push_access(1'b0, 16'h7FFF, 8'h00);
    push_access(1'b0, 16'hA000, 8'h00);
    push_access(1'b1, 16'h0000, 8'h0A);
    push_access(1'b0, 16'hA000, 8'h00);
    push_access(1'b1, 16'h3FFF, 8'h00);
    push_access(1'b0, 16'h4000, 8'h00);
    push_access(1'b1, 16'h2000, 8'hFF);
    push_access(1'b0, 16'h5FFF, 8'h00);
    push_access(1'b1, 16'h2000, 8'h02);
    push_access(1'b0, 16'h4001, 8'h00);
    push_access(1'b1, 16'h4000, 8'h03);
    push_access(1'b1, 16'h6000, 8'h01);
    push_access(1'b0, 16'h0000, 8'h00);
    push_access(1'b0, 16'h8000, 8'h00);
    push_access(1'b1, 16'h9FFF, 8'hFF);
    push_access(1'b0, 16'hC000, 8'h00);
    push_access(1'b1, 16'hFFFF, 8'hFF);
    push_access(1'b1, 16'h1FFF, 8'h1B);
    push_access(1'b1, 16'h7FFF, 8'hFE);
    drain();

    // single bank: upper window bumps past the ROM; RAM in both modes
    cfg_write(CFG_ROM_BANK_COUNT, 16'd1);
    cfg_write(CFG_RAM_SIZE, 16'd8192);
    push_access(1'b0, 16'h4000, 8'h00);
    push_access(1'b1, 16'h0000, 8'h0A);
    push_access(1'b1, 16'hBFFF, 8'h55);
    push_access(1'b0, 16'hA000, 8'h00);
    push_access(1'b1, 16'h6000, 8'h01);
    push_access(1'b1, 16'h4000, 8'h01);
    push_access(1'b0, 16'hA000, 8'h00);
    random_run(150);

    // no ROM at all, full RAM
    cfg_write(CFG_ROM_BANK_COUNT, 16'd0);
    cfg_write(CFG_RAM_SIZE, 16'd32768);
    push_access(1'b0, 16'h0000, 8'h00);
    push_access(1'b0, 16'h7FFF, 8'h00);
    random_run(150);

    // count beyond the maximum saturates
    cfg_write(CFG_ROM_BANK_COUNT, 16'hFFFF);
    random_run(250);

    cfg_write(CFG_ROM_BANK_COUNT, {8'h00, MAX_ROM_BANKS});
    random_run(250);

    cfg_write(CFG_ROM_BANK_COUNT, 16'd127);
    cfg_write(CFG_RAM_SIZE, 16'd0);
    random_run(150);

    cfg_write(CFG_ROM_BANK_COUNT, 16'd200);
    cfg_write(CFG_RAM_SIZE, 16'd8191);
    random_run(150);

    for (int p = 0; p < 4; p++) begin
      cfg_write(CFG_ROM_BANK_COUNT, 16'($urandom_range(1, 128)));
      cfg_write(CFG_RAM_SIZE, 16'($urandom_range(0, 32768)));
      random_run(150);
    end

    repeat (15) @(negedge clk);
    if (errors == 0 && mapping_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
